// ----- rtl/core/kts_pkg.sv -----
// Shared constants, operation codes and controller/datapath interface types.
package kts_pkg;

  localparam int MAX_KEYS       = 64;
  localparam int MAX_COMPONENTS = 4;
  localparam int KEY_AW         = $clog2(MAX_KEYS);
  localparam int COMP_AW        = $clog2(MAX_COMPONENTS);
  localparam int ENTRY_AW       = KEY_AW + COMP_AW;
  localparam int ENTRIES        = MAX_KEYS * MAX_COMPONENTS;
  localparam int CFG_IDX_W      = 3;
  localparam int STEP_W         = 6;
  localparam int MOD_STEPS      = 33;
  localparam int DIV_STEPS      = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_DUR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_COUNT = 3'd5;

  // Interpolation modes.
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  typedef enum logic [5:0] {
    OP_NONE, OP_WRITE, OP_MOD_INIT, OP_MOD_STEP, OP_MOD_FIN, OP_NOWRAP,
    OP_RD_FIRST, OP_RD_LAST, OP_K0_FIRST, OP_K0_LAST, OP_SRCH_INIT, OP_RD_MID,
    OP_SRCH_STEP, OP_K0_LO, OP_RD_K0, OP_CAP_T0, OP_CAP_DT, OP_DIV_INIT,
    OP_DIV_STEP, OP_SQ_U, OP_CUBE_U, OP_BASIS, OP_RD_A0, OP_CAP_P0, OP_CAP_P1,
    OP_HOLD_ACC, OP_LIN_ACC, OP_M0A, OP_M0B, OP_M1A, OP_M1B,
    OP_H0, OP_H1, OP_H2, OP_H3, OP_H4, OP_H5, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic req_sample;
    logic wrap_on;
    logic n_le1;
    logic wt_gt;
    logic wt_lt;
    logic len_zero;
    logic hold;
    logic cubic;
    logic div_need;
    logic last;
  } dp_status_t;

endpackage

// ----- rtl/core/keyframe_track_sampler_top.sv -----
// Top level of the keyframe track sampler: controller, datapath and checks.
//
// An item is taken when start is high and busy is low. req_type 0 writes one
// key: its time and one component of value and tangents. req_type 1 samples the
// track at sample_time and produces one result per component, each shown for
// a single cycle with result_valid high; last_component marks the final one.
// The receiver cannot stall, so results leave as soon as they are ready.
// A write item is taken and then written to the key stores. A sample item is taken
// and dispatched, wrapped by a serial modulo when looping is on, checked against
// the end keys and searched by binary search probes, then the lower key is read.
// The interval set-up, the 16-step divide for u and the basis follow (no divide
// when none is needed, none of these when an end key is held or in step mode),
// then each component is output by linear, step or cubic Hermite evaluation, all
// paced by the shared multiplier and the single read port of each key store.
// Configuration writes on cfg_valid/cfg_data/cfg_index are always ready and
// must only be made while busy is low. Reset clears the configuration to its
// defaults and returns the controller to idle; the key stores are left as
// they are and must be written before they are sampled.
module keyframe_track_sampler_top import kts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [KEY_AW-1:0]    key_index,
  input  logic [COMP_AW-1:0]   comp_index,
  input  logic signed [31:0]   key_time,
  input  logic signed [31:0]   key_value,
  input  logic signed [31:0]   in_slope,
  input  logic signed [31:0]   out_slope,
  input  logic signed [31:0]   sample_time,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 result_valid,
  output logic [COMP_AW-1:0]   out_component,
  output logic signed [31:0]   out_value,
  output logic signed [31:0]   wrapped_time,
  output logic                 last_component
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  kts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  kts_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .key_index      (key_index),
    .comp_index     (comp_index),
    .key_time       (key_time),
    .key_value      (key_value),
    .in_slope       (in_slope),
    .out_slope      (out_slope),
    .sample_time    (sample_time),
    .result_valid   (result_valid),
    .out_component  (out_component),
    .out_value      (out_value),
    .wrapped_time   (wrapped_time),
    .last_component (last_component)
  );

  // An accepted item always keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted item");

  // More components follow a non-final result, so the block stays busy.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_component |-> busy)
    else $error("block idle while components remain");

  // Results are spaced by the per-component sequence.
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results in consecutive cycles");

endmodule

// ----- rtl/core/kts_datapath.sv -----
// Datapath: configuration, key stores, wrap, search, divide, shared multiplier and results.
module kts_datapath import kts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  req_type,
  input  logic [KEY_AW-1:0]     key_index,
  input  logic [COMP_AW-1:0]    comp_index,
  input  logic signed [31:0]    key_time,
  input  logic signed [31:0]    key_value,
  input  logic signed [31:0]    in_slope,
  input  logic signed [31:0]    out_slope,
  input  logic signed [31:0]    sample_time,
  output logic                  result_valid,
  output logic [COMP_AW-1:0]    out_component,
  output logic signed [31:0]    out_value,
  output logic signed [31:0]    wrapped_time,
  output logic                  last_component
);

  localparam logic [16:0] U_ONE = 17'h10000;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic same;
    same = (&x[49:31]) || !(|x[49:31]);
    if (same) return x[31:0];
    return x[49] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  // Configuration registers.
  logic signed [31:0] clip_start;
  logic [30:0]        clip_duration;
  logic               loop_enable;
  logic [1:0]         interp_mode;
  logic [6:0]         key_count;
  logic [2:0]         component_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_start      <= '0;
      clip_duration   <= '0;
      loop_enable     <= 1'b0;
      interp_mode     <= MODE_LINEAR;
      key_count       <= 7'd1;
      component_count <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CLIP_START: clip_start      <= cfg_data;
        CFG_CLIP_DUR:   clip_duration   <= cfg_data[30:0];
        CFG_LOOP_EN:    loop_enable     <= cfg_data[0];
        CFG_MODE:       interp_mode     <= cfg_data[1:0];
        CFG_KEY_COUNT:  key_count       <= cfg_data[6:0];
        CFG_COMP_COUNT: component_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective key and component counts.
  logic [6:0] n_eff;
  logic [2:0] cc_eff;
  logic [6:0] n_m1;

  always_comb begin
    if (key_count == 7'd0) n_eff = 7'd1;
    else if (key_count > 7'(MAX_KEYS)) n_eff = 7'(MAX_KEYS);
    else n_eff = key_count;
    if (component_count == 3'd0) cc_eff = 3'd1;
    else if (component_count > 3'(MAX_COMPONENTS)) cc_eff = 3'(MAX_COMPONENTS);
    else cc_eff = component_count;
    n_m1 = n_eff - 7'd1;
  end

  // Latched item.
  logic                  req_sample_r;
  logic [KEY_AW-1:0]     key_r;
  logic [COMP_AW-1:0]    comp_r;
  logic signed [31:0]    ktime_r, kval_r, kin_r, kout_r, stime_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_sample_r <= req_type;
      key_r        <= key_index;
      comp_r       <= comp_index;
      ktime_r      <= key_time;
      kval_r       <= key_value;
      kin_r        <= in_slope;
      kout_r       <= out_slope;
      stime_r      <= sample_time;
    end
  end

  // Search state and key indexes.
  logic [6:0]         lo, len;
  logic [6:0]         half, mid;
  logic [KEY_AW-1:0]  k0;
  logic [6:0]         k1_full;
  logic [COMP_AW-1:0] comp;

  assign half    = len >> 1;
  assign mid     = lo + half;
  assign k1_full = {1'b0, k0} + 7'd1;

  // Store addresses follow the current operation.
  logic [KEY_AW-1:0]   t_addr;
  logic [ENTRY_AW-1:0] e_addr;

  always_comb begin
    case (cmd.op)
      OP_RD_LAST: t_addr = n_m1[KEY_AW-1:0];
      OP_RD_MID:  t_addr = mid[KEY_AW-1:0];
      OP_RD_K0:   t_addr = k0;
      OP_CAP_T0:  t_addr = k1_full[KEY_AW-1:0];
      default:    t_addr = '0;
    endcase
    case (cmd.op)
      OP_CAP_P0: e_addr = {k1_full[KEY_AW-1:0], comp};
      default:   e_addr = {k0, comp};
    endcase
  end

  // Key stores.
  logic signed [31:0] time_mem  [MAX_KEYS];
  logic signed [31:0] value_mem [ENTRIES];
  logic signed [31:0] in_mem    [ENTRIES];
  logic signed [31:0] out_mem   [ENTRIES];
  logic signed [31:0] tq, vq, iq, oq;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) time_mem[key_r] <= ktime_r;
    tq <= time_mem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      value_mem[{key_r, comp_r}] <= kval_r;
      in_mem[{key_r, comp_r}]    <= kin_r;
      out_mem[{key_r, comp_r}]   <= kout_r;
    end
    vq <= value_mem[e_addr];
    iq <= in_mem[e_addr];
    oq <= out_mem[e_addr];
  end

  // Wrap into the clip by a serial floored modulo.
  logic signed [31:0] wt;
  logic               mneg;
  logic [32:0]        msh;
  logic [30:0]        mrem;
  logic signed [32:0] mx;
  logic [31:0]        mrem2;
  logic [30:0]        mlocal;
  logic signed [33:0] msum;

  always_comb begin
    mx     = {stime_r[31], stime_r} - {clip_start[31], clip_start};
    mrem2  = {mrem, msh[32]};
    mlocal = (mneg && mrem != '0) ? clip_duration - mrem : mrem;
    msum   = {{2{clip_start[31]}}, clip_start} + {3'b000, mlocal};
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MOD_INIT: begin
        mneg <= mx[32];
        msh  <= mx[32] ? 33'(-mx) : mx;
        mrem <= '0;
      end
      OP_MOD_STEP: begin
        msh <= msh << 1;
        if (mrem2 >= {1'b0, clip_duration}) mrem <= 31'(mrem2 - {1'b0, clip_duration});
        else mrem <= mrem2[30:0];
      end
      OP_MOD_FIN: wt <= sat32({{16{msum[33]}}, msum});
      OP_NOWRAP:  wt <= stime_r;
      default: ;
    endcase
  end

  // Binary search over key times.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_K0_FIRST:  k0 <= '0;
      OP_K0_LAST:   k0 <= n_m1[KEY_AW-1:0];
      OP_K0_LO:     k0 <= (lo == 7'd0) ? '0 : 6'(lo - 7'd1);
      OP_SRCH_INIT: begin
        lo  <= '0;
        len <= n_eff;
      end
      OP_SRCH_STEP: begin
        if (!(wt < tq)) begin
          lo  <= mid + 7'd1;
          len <= len - half - 7'd1;
        end else begin
          len <= half;
        end
      end
      default: ;
    endcase
  end

  // Interval and serial divide for u.
  logic signed [31:0] t0;
  logic signed [32:0] dt;
  logic signed [32:0] xd;
  logic [31:0]        dtu;
  logic [31:0]        drem;
  logic [32:0]        dr2;
  logic [16:0]        u, u2;
  logic               div_need;

  always_comb begin
    xd       = {wt[31], wt} - {t0[31], t0};
    dr2      = {drem, 1'b0};
    div_need = (dt > 33'sd0) && (wt > t0) && (xd < dt);
  end

  // Shared multiplier and accumulator.
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic               mul_sh;
  logic [1:0]         base_sel;
  logic               acc_en;
  logic signed [51:0] prod;
  logic signed [65:0] sh_prod, acc_base, acc;
  logic signed [31:0] p0, p1, os0, is1;
  logic signed [47:0] m0, m1;
  logic signed [17:0] h00, h01, h10, h11;
  logic signed [33:0] pdiff;

  localparam logic [1:0] BASE_ZERO = 2'd0;
  localparam logic [1:0] BASE_ACC  = 2'd1;
  localparam logic [1:0] BASE_P0   = 2'd2;

  always_comb begin
    pdiff    = {p1[31], p1[31], p1} - {p0[31], p0[31], p0};
    mul_a    = '0;
    mul_b    = '0;
    mul_sh   = 1'b0;
    base_sel = BASE_ZERO;
    acc_en   = 1'b1;
    case (cmd.op)
      OP_SQ_U: begin
        mul_a = {17'd0, u};
        mul_b = {1'b0, u};
      end
      OP_CUBE_U: begin
        mul_a = {17'd0, acc[32:16]};
        mul_b = {1'b0, u};
      end
      OP_LIN_ACC: begin
        mul_a    = pdiff;
        mul_b    = {1'b0, u};
        base_sel = BASE_P0;
      end
      OP_HOLD_ACC: base_sel = BASE_P0;
      OP_M0A: begin
        mul_a = {{2{os0[31]}}, os0};
        mul_b = {2'b00, dtu[15:0]};
      end
      OP_M0B: begin
        mul_a    = {{2{os0[31]}}, os0};
        mul_b    = {2'b00, dtu[31:16]};
        mul_sh   = 1'b1;
        base_sel = BASE_ACC;
      end
      OP_M1A: begin
        mul_a = {{2{is1[31]}}, is1};
        mul_b = {2'b00, dtu[15:0]};
      end
      OP_M1B: begin
        mul_a    = {{2{is1[31]}}, is1};
        mul_b    = {2'b00, dtu[31:16]};
        mul_sh   = 1'b1;
        base_sel = BASE_ACC;
      end
      OP_H0: begin
        mul_a = {{2{p0[31]}}, p0};
        mul_b = h00;
      end
      OP_H1: begin
        mul_a    = {{2{p1[31]}}, p1};
        mul_b    = h01;
        base_sel = BASE_ACC;
      end
      OP_H2: begin
        mul_a    = {{2{m0[47]}}, m0[47:16]};
        mul_b    = h10;
        mul_sh   = 1'b1;
        base_sel = BASE_ACC;
      end
      OP_H3: begin
        mul_a    = {18'd0, m0[15:0]};
        mul_b    = h10;
        base_sel = BASE_ACC;
      end
      OP_H4: begin
        mul_a    = {{2{m1[47]}}, m1[47:16]};
        mul_b    = h11;
        mul_sh   = 1'b1;
        base_sel = BASE_ACC;
      end
      OP_H5: begin
        mul_a    = {18'd0, m1[15:0]};
        mul_b    = h11;
        base_sel = BASE_ACC;
      end
      default: acc_en = 1'b0;
    endcase
    prod    = mul_a * mul_b;
    sh_prod = mul_sh ? {prod[49:0], 16'd0} : {{14{prod[51]}}, prod};
    case (base_sel)
      BASE_ACC: acc_base = acc;
      BASE_P0:  acc_base = {{18{p0[31]}}, p0, 16'd0};
      default:  acc_base = '0;
    endcase
  end

  // Hermite basis from u, u2 and u3 (u3 taken from the accumulator).
  logic signed [19:0] us, u2s, u3s;
  assign us  = {3'b000, u};
  assign u2s = {3'b000, u2};
  assign u3s = {3'b000, acc[32:16]};

  always_ff @(posedge clk) begin
    if (acc_en) acc <= acc_base + sh_prod;
    case (cmd.op)
      OP_CAP_T0: t0 <= tq;
      OP_CAP_DT: dt <= {tq[31], tq} - {t0[31], t0};
      OP_DIV_INIT: begin
        dtu  <= (dt > 33'sd0) ? dt[31:0] : 32'd0;
        drem <= xd[31:0];
        if (dt <= 33'sd0) u <= (wt > t0) ? U_ONE : '0;
        else if (!(wt > t0)) u <= '0;
        else if (!(xd < dt)) u <= U_ONE;
        else u <= '0;
      end
      OP_DIV_STEP: begin
        if (dr2 >= {1'b0, dtu}) begin
          drem <= 32'(dr2 - {1'b0, dtu});
          u    <= {u[15:0], 1'b1};
        end else begin
          drem <= dr2[31:0];
          u    <= {u[15:0], 1'b0};
        end
      end
      OP_CUBE_U: u2 <= acc[32:16];
      OP_BASIS: begin
        h00 <= 18'((u3s <<< 1) - 20'(3 * u2s) + 20'sd65536);
        h10 <= 18'(u3s - (u2s <<< 1) + us);
        h01 <= 18'(20'(3 * u2s) - (u3s <<< 1));
        h11 <= 18'(u3s - u2s);
      end
      OP_CAP_P0: begin
        p0  <= vq;
        os0 <= oq;
      end
      OP_CAP_P1: begin
        p1  <= vq;
        is1 <= iq;
      end
      OP_M1A: m0 <= acc[63:16];
      OP_H0:  m1 <= acc[63:16];
      default: ;
    endcase
  end

  // Component counter.
  logic last;
  assign last = ({1'b0, comp} + 3'd1) == cc_eff;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD_K0) comp <= '0;
    else if (cmd.op == OP_OUT) comp <= comp + 1'b1;
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == OP_OUT);
    end
    if (cmd.op == OP_OUT) begin
      out_component  <= comp;
      out_value      <= sat32(acc[65:16]);
      wrapped_time   <= wt;
      last_component <= last;
    end
  end

  // Status for the controller.
  always_comb begin
    status.req_sample = req_sample_r;
    status.wrap_on    = loop_enable && (clip_duration != '0);
    status.n_le1      = n_eff <= 7'd1;
    status.wt_gt      = wt > tq;
    status.wt_lt      = wt < tq;
    status.len_zero   = len == 7'd0;
    status.hold       = (k1_full >= n_eff) || (interp_mode == MODE_STEP);
    status.cubic      = interp_mode == MODE_CUBIC;
    status.div_need   = div_need;
    status.last       = last;
  end

endmodule

// ----- rtl/core/kts_ctrl.sv -----
// Controller: sequences the datapath through wrap, search, divide and per-component work.
module kts_ctrl import kts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_MOD, S_MOD_FIN, S_RD_FIRST, S_CHK_FIRST, S_CHK_LAST,
    S_SMID, S_SCMP, S_PREP, S_T0, S_DT, S_DIV_INIT, S_DIV, S_SQ, S_CUBE, S_BASIS,
    S_C_RD0, S_C_RD1, S_C_RD2, S_HOLD, S_LIN, S_M0A, S_M0B, S_M1A, S_M1B,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_OUT
  } state_t;

  state_t             state, state_next;
  logic [STEP_W-1:0]  cnt, cnt_next;

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.accept = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!status.req_sample) begin
          cmd.op     = OP_WRITE;
          state_next = S_IDLE;
        end else if (status.wrap_on) begin
          cmd.op     = OP_MOD_INIT;
          cnt_next   = '0;
          state_next = S_MOD;
        end else begin
          cmd.op     = OP_NOWRAP;
          state_next = S_RD_FIRST;
        end
      end
      S_MOD: begin
        cmd.op   = OP_MOD_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_W'(MOD_STEPS - 1)) state_next = S_MOD_FIN;
      end
      S_MOD_FIN: begin
        cmd.op     = OP_MOD_FIN;
        state_next = S_RD_FIRST;
      end
      S_RD_FIRST: begin
        cmd.op     = OP_RD_FIRST;
        state_next = S_CHK_FIRST;
      end
      S_CHK_FIRST: begin
        if (status.n_le1 || !status.wt_gt) begin
          cmd.op     = OP_K0_FIRST;
          state_next = S_PREP;
        end else begin
          cmd.op     = OP_RD_LAST;
          state_next = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (!status.wt_lt) begin
          cmd.op     = OP_K0_LAST;
          state_next = S_PREP;
        end else begin
          cmd.op     = OP_SRCH_INIT;
          state_next = S_SMID;
        end
      end
      S_SMID: begin
        if (status.len_zero) begin
          cmd.op     = OP_K0_LO;
          state_next = S_PREP;
        end else begin
          cmd.op     = OP_RD_MID;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.op     = OP_SRCH_STEP;
        state_next = S_SMID;
      end
      S_PREP: begin
        cmd.op     = OP_RD_K0;
        state_next = status.hold ? S_C_RD0 : S_T0;
      end
      S_T0: begin
        cmd.op     = OP_CAP_T0;
        state_next = S_DT;
      end
      S_DT: begin
        cmd.op     = OP_CAP_DT;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op   = OP_DIV_INIT;
        cnt_next = '0;
        state_next = status.div_need ? S_DIV : S_SQ;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_W'(DIV_STEPS - 1)) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op     = OP_SQ_U;
        state_next = S_CUBE;
      end
      S_CUBE: begin
        cmd.op     = OP_CUBE_U;
        state_next = S_BASIS;
      end
      S_BASIS: begin
        cmd.op     = OP_BASIS;
        state_next = S_C_RD0;
      end
      S_C_RD0: begin
        cmd.op     = OP_RD_A0;
        state_next = S_C_RD1;
      end
      S_C_RD1: begin
        cmd.op     = OP_CAP_P0;
        state_next = S_C_RD2;
      end
      S_C_RD2: begin
        cmd.op = OP_CAP_P1;
        if (status.hold) state_next = S_HOLD;
        else if (status.cubic) state_next = S_M0A;
        else state_next = S_LIN;
      end
      S_HOLD: begin
        cmd.op     = OP_HOLD_ACC;
        state_next = S_OUT;
      end
      S_LIN: begin
        cmd.op     = OP_LIN_ACC;
        state_next = S_OUT;
      end
      S_M0A: begin
        cmd.op     = OP_M0A;
        state_next = S_M0B;
      end
      S_M0B: begin
        cmd.op     = OP_M0B;
        state_next = S_M1A;
      end
      S_M1A: begin
        cmd.op     = OP_M1A;
        state_next = S_M1B;
      end
      S_M1B: begin
        cmd.op     = OP_M1B;
        state_next = S_H0;
      end
      S_H0: begin
        cmd.op     = OP_H0;
        state_next = S_H1;
      end
      S_H1: begin
        cmd.op     = OP_H1;
        state_next = S_H2;
      end
      S_H2: begin
        cmd.op     = OP_H2;
        state_next = S_H3;
      end
      S_H3: begin
        cmd.op     = OP_H3;
        state_next = S_H4;
      end
      S_H4: begin
        cmd.op     = OP_H4;
        state_next = S_H5;
      end
      S_H5: begin
        cmd.op     = OP_H5;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.op     = OP_OUT;
        state_next = status.last ? S_IDLE : S_C_RD0;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ----- sim/kts_checker.sv -----
// Checker for the keyframe track sampler: predicts sampled values and compares results.
module kts_checker import kts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 req_type,
  input  logic [KEY_AW-1:0]    key_index,
  input  logic [COMP_AW-1:0]   comp_index,
  input  logic signed [31:0]   key_time,
  input  logic signed [31:0]   key_value,
  input  logic signed [31:0]   in_slope,
  input  logic signed [31:0]   out_slope,
  input  logic signed [31:0]   sample_time,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 result_valid,
  input  logic [COMP_AW-1:0]   out_component,
  input  logic signed [31:0]   out_value,
  input  logic signed [31:0]   wrapped_time,
  input  logic                 last_component,
  output int                   errors,
  output int                   pending
);

  typedef struct {
    logic [COMP_AW-1:0] comp;
    logic [31:0]        value;
    logic [31:0]        wtime;
    logic               last;
  } sample_result_t;

  sample_result_t expected_samples[$];

  // Shadow copy of the configuration and of the key stores.
  logic signed [31:0] clip_start_q;
  logic [30:0]        clip_dur_q;
  logic               loop_q;
  logic [1:0]         mode_q;
  logic [6:0]         key_count_q;
  logic [2:0]         comp_count_q;
  logic signed [31:0] time_mem[MAX_KEYS];
  logic signed [31:0] value_mem[ENTRIES];
  logic signed [31:0] in_mem[ENTRIES];
  logic signed [31:0] out_mem[ENTRIES];

  assign pending = expected_samples.size();

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Upper-bound search for the key at or below t, clamped at both ends.
  function automatic int lower_key(longint t, int n);
    int lo, len, half, mid;
    lo = 0;
    len = n;
    if (n <= 1 || t <= longint'(time_mem[0])) return 0;
    if (t >= longint'(time_mem[n-1])) return n - 1;
    while (len > 0) begin
      half = len / 2;
      mid = lo + half;
      if (!(t < longint'(time_mem[mid]))) begin
        lo = mid + 1;
        len -= half + 1;
      end else begin
        len = half;
      end
    end
    return (lo == 0) ? 0 : lo - 1;
  endfunction

  // Works out every component result of one sample item.
  task automatic sample_track(logic signed [31:0] st);
    int n, cc, k0, k1, c, a0, a1;
    longint t, wt, ofs, t0, dt, u, u2, u3, h00, h10, h01, h11, p0, p1, m0, m1, v;
    logic hold;
    sample_result_t r;
    n = (key_count_q == 0) ? 1 : ((key_count_q > MAX_KEYS) ? MAX_KEYS : key_count_q);
    cc = (comp_count_q == 0) ? 1 :
         ((comp_count_q > MAX_COMPONENTS) ? MAX_COMPONENTS : comp_count_q);
    t = longint'(st);
    wt = t;
    if (loop_q && clip_dur_q > 0) begin
      ofs = (t - longint'(clip_start_q)) % longint'(clip_dur_q);
      if (ofs < 0) ofs += longint'(clip_dur_q);
      wt = clamp32(longint'(clip_start_q) + ofs);
    end
    k0 = lower_key(wt, n);
    k1 = k0 + 1;
    hold = (k0 + 1 >= n) || (mode_q == MODE_STEP);
    t0 = 0;
    dt = 0;
    u = 0;
    if (!hold) begin
      t0 = longint'(time_mem[k0]);
      dt = longint'(time_mem[k1]) - t0;
      if (dt <= 0) begin
        dt = 0;
        u = (wt > t0) ? 65536 : 0;
      end else if (wt <= t0) begin
        u = 0;
      end else begin
        u = ((wt - t0) <<< 16) / dt;
        if (u > 65536) u = 65536;
      end
    end
    u2 = (u * u) >>> 16;
    u3 = (u2 * u) >>> 16;
    h00 = 2 * u3 - 3 * u2 + 65536;
    h10 = u3 - 2 * u2 + u;
    h01 = -2 * u3 + 3 * u2;
    h11 = u3 - u2;
    for (c = 0; c < cc; c++) begin
      a0 = k0 * MAX_COMPONENTS + c;
      if (hold) begin
        v = longint'(value_mem[a0]);
      end else begin
        a1 = k1 * MAX_COMPONENTS + c;
        p0 = longint'(value_mem[a0]);
        p1 = longint'(value_mem[a1]);
        if (mode_q == MODE_CUBIC) begin
          m0 = (dt * longint'(out_mem[a0])) >>> 16;
          m1 = (dt * longint'(in_mem[a1])) >>> 16;
          v = clamp32((h00 * p0 + h10 * m0 + h01 * p1 + h11 * m1) >>> 16);
        end else begin
          v = clamp32(p0 + (((p1 - p0) * u) >>> 16));
        end
      end
      r.comp = c[COMP_AW-1:0];
      r.value = v[31:0];
      r.wtime = wt[31:0];
      r.last = (c + 1 == cc);
      expected_samples.insert(expected_samples.size(), r);
    end
  endtask

  // Compare results first, then take configuration writes and new items.
  always @(posedge clk) begin
    sample_result_t e;
    if (rst) begin
      errors = 0;
      clip_start_q <= '0;
      clip_dur_q <= '0;
      loop_q <= 1'b0;
      mode_q <= MODE_LINEAR;
      key_count_q <= 7'd1;
      comp_count_q <= 3'd1;
      expected_samples.delete();
    end else begin
      if (result_valid) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected result comp=%0d value=%0d wrapped=%0d last=%0d",
                   $time, out_component, out_value, wrapped_time, last_component);
        end else begin
          e = expected_samples.pop_front();
          if (out_component !== e.comp) begin
            errors++;
            $display("%0t: out_component expected %0d actual %0d", $time, e.comp,
                     out_component);
          end
          if (out_value !== e.value) begin
            errors++;
            $display("%0t: out_value expected %0d actual %0d", $time,
                     $signed(e.value), out_value);
          end
          if (wrapped_time !== e.wtime) begin
            errors++;
            $display("%0t: wrapped_time expected %0d actual %0d", $time,
                     $signed(e.wtime), wrapped_time);
          end
          if (last_component !== e.last) begin
            errors++;
            $display("%0t: last_component expected %0d actual %0d", $time, e.last,
                     last_component);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLIP_START: clip_start_q <= cfg_data;
          CFG_CLIP_DUR:   clip_dur_q <= cfg_data[30:0];
          CFG_LOOP_EN:    loop_q <= cfg_data[0];
          CFG_MODE:       mode_q <= cfg_data[1:0];
          CFG_KEY_COUNT:  key_count_q <= cfg_data[6:0];
          CFG_COMP_COUNT: comp_count_q <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (req_type == 1'b0) begin
          time_mem[key_index] = key_time;
          value_mem[{key_index, comp_index}] = key_value;
          in_mem[{key_index, comp_index}] = in_slope;
          out_mem[{key_index, comp_index}] = out_slope;
        end else begin
          sample_track(sample_time);
        end
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the keyframe track sampler: stimulus, timeout and verdict.
module tb_top import kts_pkg::*;;

  localparam int CYCLE_LIMIT = 2000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 req_type = 1'b0;
  logic [KEY_AW-1:0]    key_index = '0;
  logic [COMP_AW-1:0]   comp_index = '0;
  logic signed [31:0]   key_time = '0;
  logic signed [31:0]   key_value = '0;
  logic signed [31:0]   in_slope = '0;
  logic signed [31:0]   out_slope = '0;
  logic signed [31:0]   sample_time = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 result_valid;
  logic [COMP_AW-1:0]   out_component;
  logic signed [31:0]   out_value;
  logic signed [31:0]   wrapped_time;
  logic                 last_component;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   idle_pct = 0;
  longint               track_times[MAX_KEYS];

  always #5 clk = ~clk;

  keyframe_track_sampler_top uut (.*);

  kts_checker chk (.*);

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Full-range words half the time, with the extremes and small values mixed in.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      3: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and returns once it has been taken.
  task automatic put_item(logic rt, logic [KEY_AW-1:0] k, logic [COMP_AW-1:0] c,
                          logic [31:0] kt, logic [31:0] kv, logic [31:0] is,
                          logic [31:0] os, logic [31:0] st);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_type <= rt;
    key_index <= k;
    comp_index <= c;
    key_time <= kt;
    key_value <= kv;
    in_slope <= is;
    out_slope <= os;
    sample_time <= st;
    start <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_key(int k, int c, logic [31:0] kt);
    put_item(1'b0, k[KEY_AW-1:0], c[COMP_AW-1:0], kt, rand_word(), rand_word(),
             rand_word(), $urandom);
  endtask

  task automatic sample_at(logic [31:0] st);
    put_item(1'b1, KEY_AW'($urandom), COMP_AW'($urandom), $urandom, $urandom, $urandom,
             $urandom, st);
  endtask

  // Lets every expected result arrive, then allows the block to settle.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
  endtask

  // Writes all six registers; unused upper data bits carry noise.
  task automatic set_config(logic [31:0] cs, logic [30:0] dur, logic lp, logic [1:0] md,
                            logic [6:0] kc, logic [2:0] cc);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(CFG_CLIP_START, cs);
    write_reg(CFG_CLIP_DUR, {noise[31], dur});
    write_reg(CFG_LOOP_EN, {noise[31:1], lp});
    write_reg(CFG_MODE, {noise[31:2], md});
    write_reg(CFG_KEY_COUNT, {noise[31:7], kc});
    write_reg(CFG_COMP_COUNT, {noise[31:3], cc});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase, i, k, c, n, cc, kc_raw, cc_raw, pick;
    longint t, lo_t, hi_t;
    logic [1:0] md;
    logic [31:0] cs;
    logic [30:0] dur;
    logic unsorted;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset configuration, a single key, extreme sample times.
    write_key(0, 0, 32'h7fff_ffff);
    sample_at(32'h8000_0000);
    sample_at(32'h7fff_ffff);
    sample_at(32'h0);
    drain();

    // Directed: cubic over four keys with a zero-length interval and a huge one.
    set_config(32'h0, 31'd0, 1'b0, MODE_CUBIC, 7'd4, 3'd2);
    track_times[0] = -65536;
    track_times[1] = 0;
    track_times[2] = 0;
    track_times[3] = 64'sd2147483647;
    for (k = 0; k < 4; k++)
      for (c = 0; c < 2; c++)
        write_key(k, c, track_times[k][31:0]);
    sample_at(32'h8000_0000);
    sample_at(-32768);
    sample_at(32'h0);
    sample_at(32'h1);
    sample_at(32'h4000_0000);
    sample_at(32'h7fff_ffff);
    drain();
    set_config(32'h0, 31'd0, 1'b0, MODE_STEP, 7'd4, 3'd2);
    sample_at(-32768);
    sample_at(32'h4000_0000);
    drain();
    // Mode three behaves as linear; looping wraps a far sample into the clip.
    set_config(-65536, 31'd131072, 1'b1, 2'd3, 7'd4, 3'd2);
    sample_at(32'h7fff_ffff);
    sample_at(32'h8000_0000);
    drain();

    // Random phases: a fresh track and configuration each time.
    for (phase = 0; phase < 9; phase++) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 83;
        default: idle_pct = 11;
      endcase
      if (phase == 3) begin
        kc_raw = 64;
        cc_raw = 1;
      end else if (phase == 8) begin
        kc_raw = 127;
        cc_raw = 0;
      end else begin
        pick = $urandom_range(5);
        kc_raw = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 2 : $urandom_range(3, 8);
        cc_raw = $urandom_range(7);
      end
      n = (kc_raw == 0) ? 1 : ((kc_raw > MAX_KEYS) ? MAX_KEYS : kc_raw);
      cc = (cc_raw == 0) ? 1 : ((cc_raw > MAX_COMPONENTS) ? MAX_COMPONENTS : cc_raw);
      md = 2'($urandom_range(3));
      unsorted = (phase % 5 == 4);

      // Build an ascending track, with repeated times now and then, or a random unsorted one when unsorted is set.
      t = longint'($signed($urandom_range(0, 2097152))) - 1048576;
      for (k = 0; k < n; k++) begin
        if (unsorted) t = longint'($signed(rand_word()));
        else if (k > 0 && $urandom_range(7) != 0) t += $urandom_range(1, 262144);
        track_times[k] = t;
      end
      pick = $urandom_range(4);
      cs = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7fff_ffff :
           (pick == 2) ? 32'h0 : track_times[0][31:0];
      pick = $urandom_range(4);
      dur = (pick == 0) ? 31'd0 : (pick == 1) ? 31'd1 : (pick == 2) ? 31'h7fff_ffff :
            31'($urandom_range(1, 1048576));
      set_config(cs, dur, 1'($urandom_range(1)), md, kc_raw[6:0], cc_raw[2:0]);

      for (k = 0; k < n; k++)
        for (c = 0; c < cc; c++)
          write_key(k, c, track_times[k][31:0]);
      // A stray write to an unused key leaves the track in use untouched.
      if (n < MAX_KEYS) write_key($urandom_range(n, MAX_KEYS - 1), $urandom, $urandom);

      lo_t = track_times[0] - 65536;
      hi_t = track_times[n-1] + 65536;
      if (hi_t <= lo_t) hi_t = lo_t + 131072;
      for (i = 0; i < 12; i++) begin
        pick = $urandom_range(19);
        if (pick < 12)
          sample_at(32'(lo_t + longint'($urandom_range(0, 32'(hi_t - lo_t)))));
        else if (pick < 15)
          sample_at(track_times[$urandom_range(n - 1)][31:0]);
        else
          sample_at(rand_word());
        // Hold off once per phase until the block has caught up.
        if (i == 6) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
